// ----- design/assert_macros.svh -----
// Assertion macros shared by the controller RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/mppc_pkg.sv -----
// Types and constants of the motor position P controller.
// Used by the front, the back and the top of the block; depends on nothing.
`default_nettype none
package mppc_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int GAIN_W     = 10;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd50;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_ADDR = 2'd0;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic KIND_DRIVE     = 1'b0;
   localparam logic KIND_TELEMETRY = 1'b1;

   localparam int MAG_HIGH_INDEX = 2;
   localparam int MAG_LOW_INDEX  = 3;
   localparam logic [7:0]  SIGN_NEGATIVE = 8'd1;
   localparam logic [7:0]  START_BYTE    = 8'hFF;
   localparam logic [15:0] DUTY_MAX      = 16'hFFFF;
   // One above the largest duty; any magnitude above it saturates anyway.
   localparam logic [16:0] MAG_CAP       = 17'h10000;

   typedef struct packed {
      logic        command;
      logic [7:0]  rx_byte;
      logic [15:0] count_a;
      logic [15:0] count_b;
   } mppc_req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] duty;
      logic        direction;
      logic        direction_changed;
      logic [7:0]  tx_byte;
      logic        last;
   } mppc_rsp_type;

   // Work handed from the front to the back; the error travels beside it.
   typedef struct packed {
      logic        is_tick;
      logic        drive;
      logic [15:0] diff;
   } mppc_job_type;

   localparam int JOB_W = $bits(mppc_job_type);

endpackage
`default_nettype wire

// ----- design/mppc_fifo.sv -----
// Small register queue between the front and the back of the controller.
// Depends on assert_macros.svh only.
`default_nettype none
`include "assert_macros.svh"
module mppc_fifo #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CountW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CountW'(DEPTH))
   `ASSERT_NEXT(a_pop_frees, clock, reset, do_pop && !do_push, !full)

endmodule
`default_nettype wire

// ----- design/mppc_front.sv -----
// Front of the controller: takes input beats, assembles packets and keeps
// the position error. Depends on mppc_pkg.
`default_nettype none
module mppc_front #(
   parameter int PACKET_LENGTH = 5,
   parameter int ERROR_WIDTH   = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire mppc_pkg::mppc_req_type req,
   output logic                       job_push,
   output mppc_pkg::mppc_job_type     job,
   output logic [ERROR_WIDTH-1:0]     job_error
);

   localparam int CountW = $clog2(PACKET_LENGTH);
   localparam int W      = ERROR_WIDTH;

   logic [CountW-1:0] byte_count_ff, byte_count_in;
   logic [7:0]        mag_high_ff, mag_high_in;
   logic [7:0]        mag_low_ff, mag_low_in;
   logic              loop_active_ff, loop_active_in;
   logic [W-1:0]      error_ff, error_in;

   logic [16:0]  diff;
   logic [W:0]   sum;
   logic [W-1:0] tick_error;
   logic [W-1:0] packet_error;
   logic [15:0]  magnitude;
   logic         packet_done;

   assign magnitude   = {mag_high_ff, mag_low_ff};
   assign packet_done = (byte_count_ff == CountW'(PACKET_LENGTH - 1));
   assign diff        = {1'b0, req.count_a} - {1'b0, req.count_b};

   // Error minus difference, one bit wider, then clamped to the error range.
   assign sum = {error_ff[W-1], error_ff} - {{(W - 16){diff[16]}}, diff};

   always_comb begin
      if (sum[W] != sum[W-1]) begin
         tick_error = sum[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
      end else begin
         tick_error = sum[W-1:0];
      end
      if (req.rx_byte == mppc_pkg::SIGN_NEGATIVE) begin
         packet_error = '0 - {{(W - 16){1'b0}}, magnitude};
      end else begin
         packet_error = {{(W - 16){1'b0}}, magnitude};
      end
   end

   always_comb begin
      byte_count_in  = byte_count_ff;
      mag_high_in    = mag_high_ff;
      mag_low_in     = mag_low_ff;
      loop_active_in = loop_active_ff;
      error_in       = error_ff;
      job_push       = 1'b0;
      job.is_tick    = 1'b0;
      job.drive      = 1'b0;
      job.diff       = diff[15:0];
      if (accept) begin
         if (req.command == mppc_pkg::CMD_TICK) begin
            if (loop_active_ff) begin
               error_in = tick_error;
            end
            job_push    = 1'b1;
            job.is_tick = 1'b1;
            job.drive   = loop_active_ff && (tick_error != '0);
         end else if (packet_done) begin
            byte_count_in  = '0;
            loop_active_in = 1'b1;
            error_in       = packet_error;
            job_push       = (magnitude != '0);
            job.drive      = 1'b1;
         end else begin
            if (byte_count_ff == CountW'(mppc_pkg::MAG_HIGH_INDEX)) begin
               mag_high_in = req.rx_byte;
            end
            if (byte_count_ff == CountW'(mppc_pkg::MAG_LOW_INDEX)) begin
               mag_low_in = req.rx_byte;
            end
            byte_count_in = byte_count_ff + 1'b1;
         end
      end
   end

   assign job_error = error_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         mag_high_ff    <= '0;
         mag_low_ff     <= '0;
         loop_active_ff <= 1'b0;
         error_ff       <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         mag_high_ff    <= mag_high_in;
         mag_low_ff     <= mag_low_in;
         loop_active_ff <= loop_active_in;
         error_ff       <= error_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/mppc_back.sv -----
// Back of the controller: turns queued work into telemetry and drive beats
// behind an output register. Depends on mppc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mppc_back #(
   parameter int ERROR_WIDTH = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [mppc_pkg::GAIN_W-1:0]  gain,
   input  wire logic                         q_empty,
   input  wire mppc_pkg::mppc_job_type       q_job,
   input  wire logic [ERROR_WIDTH-1:0]       q_error,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output mppc_pkg::mppc_rsp_type            rsp_item
);

   localparam int W = ERROR_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_HIGH,
      S_LOW,
      S_DRIVE
   } state_type;

   state_type              state_ff, state_in;
   mppc_pkg::mppc_job_type job_ff;
   logic [W-1:0]           error_ff;
   logic [15:0]            duty_ff;
   logic                   last_dir_ff, last_dir_in;
   logic                   out_valid_ff, out_valid_in;
   mppc_pkg::mppc_rsp_type out_ff, out_in;

   logic                   slot_free;
   logic                   direction;
   logic                   tel_state;
   logic                   tick_pop;
   logic [W-1:0]           magnitude;
   logic [16:0]            mag_sat;
   logic [26:0]            product;
   mppc_pkg::mppc_rsp_type tel_beat;
   mppc_pkg::mppc_rsp_type drive_beat;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty && slot_free;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign tel_state = (state_ff == S_HIGH) || (state_ff == S_LOW);
   assign tick_pop  = q_pop && q_job.is_tick;

   // Magnitude is capped just above the duty range before the multiply.
   assign direction = !error_ff[W-1];
   assign magnitude = error_ff[W-1] ? ('0 - error_ff) : error_ff;
   assign mag_sat   = (magnitude > W'(mppc_pkg::MAG_CAP)) ? mppc_pkg::MAG_CAP
                                                          : magnitude[16:0];
   assign product   = 27'(mag_sat) * 27'(gain);

   always_comb begin
      tel_beat                   = '0;
      tel_beat.kind              = mppc_pkg::KIND_TELEMETRY;
      drive_beat                 = '0;
      drive_beat.kind            = mppc_pkg::KIND_DRIVE;
      drive_beat.duty            = duty_ff;
      drive_beat.direction       = direction;
      drive_beat.direction_changed = (direction != last_dir_ff);
      drive_beat.last            = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      last_dir_in  = last_dir_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               if (q_job.is_tick) begin
                  // The start byte needs nothing from the job itself.
                  out_in         = tel_beat;
                  out_in.tx_byte = mppc_pkg::START_BYTE;
                  out_valid_in   = 1'b1;
                  state_in       = S_HIGH;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            state_in = S_DRIVE;
         end
         S_HIGH: begin
            if (slot_free) begin
               out_in         = tel_beat;
               out_in.tx_byte = job_ff.diff[15:8];
               out_valid_in   = 1'b1;
               state_in       = S_LOW;
            end
         end
         S_LOW: begin
            if (slot_free) begin
               out_in         = tel_beat;
               out_in.tx_byte = job_ff.diff[7:0];
               out_in.last    = !job_ff.drive;
               out_valid_in   = 1'b1;
               state_in       = job_ff.drive ? S_DRIVE : S_IDLE;
            end
         end
         S_DRIVE: begin
            if (slot_free) begin
               out_in       = drive_beat;
               out_valid_in = 1'b1;
               last_dir_in  = direction;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (product > 27'(mppc_pkg::DUTY_MAX)) begin
         duty_ff <= mppc_pkg::DUTY_MAX;
      end else begin
         duty_ff <= product[15:0];
      end
      if (q_pop) begin
         job_ff   <= q_job;
         error_ff <= q_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_dir_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         last_dir_ff  <= last_dir_in;
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
      end
   end

   `ASSERT_IMPLY(a_drive_needs_job, clock, reset, state_ff == S_DRIVE, job_ff.drive)
   `ASSERT_IMPLY(a_bytes_for_ticks, clock, reset, tel_state, job_ff.is_tick)
   `ASSERT_NEXT(a_start_then_high, clock, reset, tick_pop, state_ff == S_HIGH && out_valid_ff)

endmodule
`default_nettype wire

// ----- design/motor_position_p_controller.sv -----
// Top level of the motor position P controller: configuration register,
// front, queue and back. Depends on mppc_pkg, mppc_front, mppc_fifo, mppc_back.
//
//   Channel   Direction  Handshake                  Beat
//   req_      in         push / full                command, byte, encoder counts
//   rsp_      out        pop / empty                drive command or telemetry byte
//   csr_      in/out     psel, penable, pready      gain register at address 0
//
// The front takes one input beat a cycle while the queue has room.
// A tick yields up to four result beats, one a cycle from the output register
// while each is popped; a packet with a drive first passes S_CALC, where the
// registered duty multiply in the back settles, and then yields its drive beat.
// Reset is synchronous and clears all control state; the gain returns to 50.
// Either side may stall freely: the queue and the output register decouple them.
`default_nettype none
module motor_position_p_controller #(
   parameter int PACKET_LENGTH = 5,
   parameter int ERROR_WIDTH   = 24,
   parameter int QUEUE_DEPTH   = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire mppc_pkg::mppc_req_type           req_item,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output mppc_pkg::mppc_rsp_type                rsp_item,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mppc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [mppc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mppc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int QW = mppc_pkg::JOB_W + ERROR_WIDTH;

   logic [mppc_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic                        gain_write;
   logic                        accept;
   logic                        job_push;
   mppc_pkg::mppc_job_type      job;
   logic [ERROR_WIDTH-1:0]      job_error;
   logic                        q_full, q_empty, q_pop;
   logic [QW-1:0]               q_data;
   mppc_pkg::mppc_job_type      q_job;
   logic [ERROR_WIDTH-1:0]      q_error;

   assign csr_pready = 1'b1;
   assign gain_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == mppc_pkg::CSR_GAIN_ADDR);
   assign gain_in    = gain_write ? csr_pwdata[mppc_pkg::GAIN_W-1:0] : gain_ff;
   assign csr_prdata = (csr_paddr == mppc_pkg::CSR_GAIN_ADDR)
                       ? {{(mppc_pkg::CSR_DATA_W - mppc_pkg::GAIN_W){1'b0}}, gain_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= mppc_pkg::GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   mppc_front #(
      .PACKET_LENGTH(PACKET_LENGTH),
      .ERROR_WIDTH  (ERROR_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_item),
      .job_push (job_push),
      .job      (job),
      .job_error(job_error)
   );

   mppc_fifo #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data({job, job_error}),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_data),
      .empty    (q_empty)
   );

   assign q_job   = q_data[QW-1:ERROR_WIDTH];
   assign q_error = q_data[ERROR_WIDTH-1:0];

   mppc_back #(
      .ERROR_WIDTH(ERROR_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .gain     (gain_ff),
      .q_empty  (q_empty),
      .q_job    (q_job),
      .q_error  (q_error),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire
